@@ rtl/core/subenum_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subenum_pkg
// Shared types and constants of the size-ordered subset enumerator.
// ----------------------------------------------------------------------------
package subenum_pkg;

    localparam int MASK_W  = 16;
    localparam int SIZE_W  = 5;
    localparam int INDEX_W = 16;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] SET_SIZE_RESET = 5'd3;

    // controller to datapath
    typedef struct packed {
        logic go_empty;
        logic scan_init;
        logic scan_step;
        logic fill_found;
        logic grow;
        logic fill_step;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic started;
        logic size_zero;
        logic hit;
        logic ptr_zero;
        logic fill_last;
        logic grow_over;
    } status_t;

endpackage

@@ rtl/core/subenum_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subenum_ctrl
// Sequencer: accepts a request, steps the member scan and refill, and
// hands the finished word to the output register.
// ----------------------------------------------------------------------------
module subenum_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                restart,
    output logic                out_valid,
    input  logic                out_ready,
    input  subenum_pkg::status_t sts,
    output subenum_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_FILL = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart || !sts.started)
                    begin
                        cmd.go_empty = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else if (sts.size_zero)
                    begin
                        if (sts.grow_over)
                        begin
                            cmd.go_empty = 1'b1;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            cmd.grow   = 1'b1;
                            state_next = ST_FILL;
                        end
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.fill_found = 1'b1;
                    state_next     = ST_FILL;
                end
                else if (sts.ptr_zero)
                begin
                    if (sts.grow_over)
                    begin
                        cmd.go_empty = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        cmd.grow   = 1'b1;
                        state_next = ST_FILL;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start work");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted word not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.emit)
        else $error("output word overwritten while stalled");

endmodule

@@ rtl/core/subenum_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subenum_dp
// Datapath: member register file, size and index counters, scan pointer,
// incremental subset mask and the output word register.
// ----------------------------------------------------------------------------
module subenum_dp
#(
    parameter int MAX_SET_SIZE = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [subenum_pkg::CFG_W-1:0]       cfg_wdata,
    input  subenum_pkg::cmd_t                   cmd,
    output subenum_pkg::status_t                sts,
    output logic [subenum_pkg::MASK_W-1:0]      subset_mask,
    output logic [subenum_pkg::SIZE_W-1:0]      subset_size,
    output logic [subenum_pkg::INDEX_W-1:0]     subset_index,
    output logic                                last_subset
);

    localparam int KW = $clog2(MAX_SET_SIZE + 1);
    localparam int PW = (MAX_SET_SIZE > 1) ? $clog2(MAX_SET_SIZE) : 1;
    localparam int SW = KW + 2;

    logic [subenum_pkg::CFG_W-1:0]   set_size_reg;
    logic [KW-1:0]                   members_reg [MAX_SET_SIZE];
    logic [KW-1:0]                   current_size_reg;
    logic [subenum_pkg::INDEX_W-1:0] count_reg;
    logic                            started_reg;
    logic [PW-1:0]                   ptr_reg;
    logic [KW-1:0]                   fill_val_reg;
    logic                            grow_reg;
    logic [subenum_pkg::MASK_W-1:0]  mask_reg;
    logic [subenum_pkg::MASK_W-1:0]  mask_next;
    logic [subenum_pkg::MASK_W-1:0]  grow_mask;

    logic [subenum_pkg::MASK_W-1:0]  subset_mask_reg;
    logic [subenum_pkg::SIZE_W-1:0]  subset_size_reg;
    logic [subenum_pkg::INDEX_W-1:0] subset_index_reg;
    logic                            last_subset_reg;

    logic [KW-1:0]                   n_eff;
    logic [KW-1:0]                   rd_member;
    logic [KW:0]                     size_plus1;

    assign n_eff = ({1'b0, set_size_reg} > 6'(MAX_SET_SIZE)) ? KW'(MAX_SET_SIZE)
                                                              : KW'(set_size_reg);
    assign rd_member  = members_reg[ptr_reg];
    assign size_plus1 = (KW+1)'(current_size_reg) + (KW+1)'(1);

    assign sts.started   = started_reg;
    assign sts.size_zero = (current_size_reg == '0);
    assign sts.hit       = (SW'(rd_member) + SW'(current_size_reg))
                           < (SW'(n_eff) + SW'(ptr_reg) + SW'(1));
    assign sts.ptr_zero  = (ptr_reg == '0);
    assign sts.fill_last = ((KW+1)'(ptr_reg) + (KW+1)'(1)) == (KW+1)'(current_size_reg);
    assign sts.grow_over = size_plus1 > (KW+1)'(n_eff);

    always_comb
    begin
        for (int b = 0; b < subenum_pkg::MASK_W; b++)
        begin
            grow_mask[b] = (b < int'(size_plus1));
        end
    end

    // swap the old member's bit for the new one
    always_comb
    begin
        mask_next = mask_reg;
        for (int b = 0; b < subenum_pkg::MASK_W; b++)
        begin
            if (int'(rd_member) == b + 1)
            begin
                mask_next[b] = 1'b0;
            end
            if (int'(fill_val_reg) == b + 1)
            begin
                mask_next[b] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg     <= subenum_pkg::SET_SIZE_RESET;
            current_size_reg <= '0;
            count_reg        <= '0;
            started_reg      <= 1'b0;
            mask_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                set_size_reg <= cfg_wdata;
            end
            if (cmd.go_empty)
            begin
                current_size_reg <= '0;
                count_reg        <= '0;
                started_reg      <= 1'b1;
                mask_reg         <= '0;
            end
            if (cmd.grow)
            begin
                current_size_reg <= KW'(size_plus1);
                mask_reg         <= grow_mask;
            end
            if (cmd.fill_step && !grow_reg)
            begin
                mask_reg <= mask_next;
            end
            if (cmd.emit)
            begin
                count_reg <= count_reg + subenum_pkg::INDEX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            ptr_reg <= PW'(current_size_reg - KW'(1));
        end
        if (cmd.scan_step)
        begin
            ptr_reg <= ptr_reg - PW'(1);
        end
        if (cmd.fill_found)
        begin
            fill_val_reg <= rd_member + KW'(1);
            grow_reg     <= 1'b0;
        end
        if (cmd.grow)
        begin
            ptr_reg      <= '0;
            fill_val_reg <= KW'(1);
            grow_reg     <= 1'b1;
        end
        if (cmd.fill_step)
        begin
            members_reg[ptr_reg] <= fill_val_reg;
            ptr_reg              <= ptr_reg + PW'(1);
            fill_val_reg         <= fill_val_reg + KW'(1);
        end
        if (cmd.emit)
        begin
            subset_mask_reg  <= mask_reg;
            subset_size_reg  <= subenum_pkg::SIZE_W'(current_size_reg);
            subset_index_reg <= count_reg;
            last_subset_reg  <= (current_size_reg >= n_eff);
        end
    end

    assign subset_mask  = subset_mask_reg;
    assign subset_size  = subset_size_reg;
    assign subset_index = subset_index_reg;
    assign last_subset  = last_subset_reg;

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_step |-> ((KW+1)'(ptr_reg) < (KW+1)'(current_size_reg)))
        else $error("refill beyond current size");

    a_empty_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.go_empty |=> (current_size_reg == '0) && (count_reg == '0) && (mask_reg == '0))
        else $error("empty set not restored");

endmodule

@@ rtl/core/subset_enumerator_by_size_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subset_enumerator_by_size_top
// Emits the subsets of {1..n} ordered by size, then lexicographically.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/restart): each accepted word requests
//   one subset. restart=1 returns to the empty set; restart=0 advances.
//   Output channel (out_valid/out_ready): one word per request carrying the
//   mask, size, running index and the full-set flag.
//   Config: cfg_we/cfg_wdata writes n (set_size); write only while idle.
// Timing:
//   A restart skips the scan and refill. An advance scans the members right
//   to left and then refills members, one member per cycle through the
//   member register file. A new word is taken the cycle after the previous
//   result is loaded into the output register.
// Reset and stall:
//   Reset sets n to 3, clears the enumeration; the first request after
//   reset always gives the empty set with index 0. If the receiver stalls,
//   the finished result waits in the output register while the next word
//   may be accepted; that word's result is held until the register frees.
// ----------------------------------------------------------------------------
module subset_enumerator_by_size_top
#(
    parameter int MAX_SET_SIZE = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [subenum_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [subenum_pkg::MASK_W-1:0]      subset_mask,
    output logic [subenum_pkg::SIZE_W-1:0]      subset_size,
    output logic [subenum_pkg::INDEX_W-1:0]     subset_index,
    output logic                                last_subset
);

    subenum_pkg::cmd_t    cmd;
    subenum_pkg::status_t sts;

    subenum_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    subenum_dp #(
        .MAX_SET_SIZE (MAX_SET_SIZE)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .sts          (sts),
        .subset_mask  (subset_mask),
        .subset_size  (subset_size),
        .subset_index (subset_index),
        .last_subset  (last_subset)
    );

endmodule

@@ sim/tb_subset_enumerator_by_size_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_subset_enumerator_by_size_top
// Self-checking bench for the size-ordered subset enumerator. A driver takes
// request words from a queue and offers them with random gaps. A predictor
// keeps its own copy of the combination state and queues the subset each
// accepted request must produce. A monitor stalls at random, holds off once
// for a long stretch so the block fills up, and compares every output word
// field by field. Phases run under many set sizes, including zero and values
// above the limit, and the set size is also changed in the middle of an
// enumeration.
// ----------------------------------------------------------------------------
module tb_subset_enumerator_by_size_top;

    localparam int          MAX_N       = 16;
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned RANDOM_REQS = 750;

    typedef struct packed {
        logic [subenum_pkg::MASK_W-1:0]  bits;
        logic [subenum_pkg::SIZE_W-1:0]  count;
        logic [subenum_pkg::INDEX_W-1:0] order;
        logic                            full;
    } subset_word_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [subenum_pkg::CFG_W-1:0]    cfg_wdata = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    logic                             restart   = 1'b0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [subenum_pkg::MASK_W-1:0]   subset_mask;
    logic [subenum_pkg::SIZE_W-1:0]   subset_size;
    logic [subenum_pkg::INDEX_W-1:0]  subset_index;
    logic                             last_subset;

    // predictor state
    logic [subenum_pkg::CFG_W-1:0]    model_n      = subenum_pkg::SET_SIZE_RESET;
    logic [subenum_pkg::SIZE_W-1:0]   chosen [MAX_N];
    logic [subenum_pkg::SIZE_W-1:0]   cur_size     = '0;
    logic [subenum_pkg::INDEX_W-1:0]  emit_count   = '0;
    logic                             enum_started = 1'b0;

    logic                pend_req [$];
    subset_word_t        expected_subsets [$];
    subset_word_t        want_word;

    bit                  quiet_phase  = 1'b0;
    int unsigned         send_gap     = 0;
    int unsigned         stall_left   = 0;
    int unsigned         hold_left    = 0;
    bit                  held_once    = 1'b0;
    int unsigned         results_seen = 0;
    int unsigned         mismatch_cnt = 0;
    int unsigned         cycle_cnt    = 0;

    subset_enumerator_by_size_top #(
        .MAX_SET_SIZE (MAX_N)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .subset_mask  (subset_mask),
        .subset_size  (subset_size),
        .subset_index (subset_index),
        .last_subset  (last_subset)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_enum();
        cur_size   = '0;
        emit_count = '0;
        foreach (chosen[j])
            chosen[j] = '0;
    endfunction

    function automatic subset_word_t next_subset(input logic rst_req);
        int unsigned                    n;
        int unsigned                    k;
        int unsigned                    pos;
        int unsigned                    base;
        bit                             found;
        logic [subenum_pkg::MASK_W-1:0] bits;
        subset_word_t                   w;
        n = (model_n > MAX_N) ? MAX_N : model_n;
        if (rst_req || !enum_started)
        begin
            clear_enum();
            enum_started = 1'b1;
        end
        else
        begin
            k     = (cur_size > MAX_N) ? MAX_N : cur_size;
            found = 1'b0;
            pos   = 0;
            // rightmost member that still has room to grow
            for (int i = int'(k); i > 0; i--)
            begin
                if (!found && (chosen[i-1] + k < n + i))
                begin
                    found = 1'b1;
                    pos   = i - 1;
                end
            end
            if (found)
            begin
                base = chosen[pos] + 1;
                for (int j = int'(pos); j < k; j++)
                    chosen[j] = subenum_pkg::SIZE_W'(base + (j - pos));
            end
            else if (k + 1 > n)
                clear_enum();
            else
            begin
                cur_size = subenum_pkg::SIZE_W'(k + 1);
                for (int j = 0; j < k + 1; j++)
                    chosen[j] = subenum_pkg::SIZE_W'(j + 1);
            end
        end
        bits = '0;
        k    = (cur_size > MAX_N) ? MAX_N : cur_size;
        for (int j = 0; j < k; j++)
        begin
            if (chosen[j] >= 1 && chosen[j] <= 16)
                bits[chosen[j] - 1] = 1'b1;
        end
        w.bits     = bits;
        w.count    = cur_size;
        w.order    = emit_count;
        w.full     = (cur_size >= n);
        emit_count = emit_count + 1'b1;
        return w;
    endfunction

    function automatic int unsigned pick_gap(input bit no_idle);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            restart  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_subsets.push_back(next_subset(restart));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pend_req.size() > 0)
                begin
                    in_valid <= 1'b1;
                    restart  <= pend_req.pop_front();
                    send_gap = pick_gap(quiet_phase);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_subsets.size() == 0)
                begin
                    $error("unexpected subset word: mask %h index %0d", subset_mask,
                           subset_index);
                    mismatch_cnt++;
                end
                else
                begin
                    want_word = expected_subsets.pop_front();
                    if (subset_mask !== want_word.bits)
                    begin
                        $error("subset_mask: expected %h, got %h", want_word.bits,
                               subset_mask);
                        mismatch_cnt++;
                    end
                    if (subset_size !== want_word.count)
                    begin
                        $error("subset_size: expected %0d, got %0d", want_word.count,
                               subset_size);
                        mismatch_cnt++;
                    end
                    if (subset_index !== want_word.order)
                    begin
                        $error("subset_index: expected %0d, got %0d", want_word.order,
                               subset_index);
                        mismatch_cnt++;
                    end
                    if (last_subset !== want_word.full)
                    begin
                        $error("last_subset: expected %b, got %b", want_word.full,
                               last_subset);
                        mismatch_cnt++;
                    end
                end
            end
            // one long hold-off while requests keep coming
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!held_once && results_seen >= 150 && pend_req.size() > 4)
            begin
                held_once = 1'b1;
                hold_left = 250;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap(1'b0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("subset_enumerator_by_size_top verification failed");
            $finish;
        end
    end

    task automatic drain();
        do
            @(negedge clk);
        while (pend_req.size() != 0 || in_valid || expected_subsets.size() != 0);
        repeat (2 * MAX_N + 8) @(negedge clk);
    endtask

    task automatic write_set_size(input logic [subenum_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        model_n   = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned                    random_sent;
        int unsigned                    phase_len;
        int unsigned                    pick;
        bit                             often_restart;
        logic [subenum_pkg::CFG_W-1:0]  n_sel;
        random_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default n of three: first word without restart, full walk and wrap
        repeat (10) pend_req.push_back(1'b0);
        pend_req.push_back(1'b1);
        drain();
        // empty base set
        write_set_size(5'd0);
        pend_req.push_back(1'b0);
        pend_req.push_back(1'b1);
        pend_req.push_back(1'b0);
        drain();
        // above the limit, saturates
        write_set_size(5'd31);
        repeat (3) pend_req.push_back(1'b0);
        drain();
        write_set_size(5'd16);
        pend_req.push_back(1'b1);
        repeat (3) pend_req.push_back(1'b0);
        drain();
        // shrink below the stored combination
        write_set_size(5'd1);
        repeat (3) pend_req.push_back(1'b0);
        drain();

        while (random_sent < RANDOM_REQS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                n_sel = subenum_pkg::CFG_W'($urandom_range(1, 6));
            else if (pick < 85)
                n_sel = subenum_pkg::CFG_W'($urandom_range(7, 16));
            else if (pick < 92)
                n_sel = subenum_pkg::CFG_W'($urandom_range(17, 31));
            else if (pick < 96)
                n_sel = 5'd0;
            else
                n_sel = model_n;
            quiet_phase   = ($urandom_range(0, 3) == 0);
            often_restart = ($urandom_range(0, 2) == 0);
            phase_len     = $urandom_range(5, 60);
            write_set_size(n_sel);
            for (int i = 0; i < phase_len; i++)
            begin
                if (often_restart)
                    pend_req.push_back($urandom_range(0, 19) == 0);
                else
                    pend_req.push_back($urandom_range(0, 199) == 0);
            end
            random_sent += phase_len;
            drain();
        end

        if (mismatch_cnt == 0 && expected_subsets.size() == 0)
            $display("subset_enumerator_by_size_top verification clean");
        else
            $display("subset_enumerator_by_size_top verification failed");
        $finish;
    end

endmodule
